// ----- rtl/mcat_pkg.sv -----
// Shared types, constants and helpers for the compare alarm timer.
`default_nettype none

package mcat_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 4;
  localparam int unsigned COUNTER_BITS_DEF = 24;
  localparam int unsigned PRESC_W          = 12;
  localparam logic [PRESC_W-1:0] PRESC_RESET = 12'd31;
  localparam int unsigned OP_W             = 2;

  // Request codes; code 3 is not assigned and changes nothing.
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_CONFIG  = 2'd1,
    OP_ONESHOT = 2'd2
  } mcat_op_t;

  // Per-channel control for one request.
  typedef struct packed {
    logic adv;           // divided tick: compare against the new count
    logic arm;           // load period, enable, and maybe the compare value
    logic en;            // enable value for an arm
    logic set_one_shot;  // mark channel as one-shot
  } mcat_chan_ctl_t;

  // Channel index width: at least the two bits of the request field.
  function automatic int unsigned chan_w(input int unsigned n);
    chan_w = (n > 4) ? 3 : 2;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mcat_prescale.sv -----
// Prescaler register, tick divider and wrapping main counter.
`default_nettype none

module mcat_prescale #(
  parameter int unsigned COUNTER_BITS = mcat_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [mcat_pkg::PRESC_W-1:0] cfg_wdata,
  input  wire logic                        tick,
  output logic                             adv,
  output logic [COUNTER_BITS-1:0]          count
);
  import mcat_pkg::*;

  logic [PRESC_W-1:0]      presc_r, presc_nxt;
  logic [PRESC_W-1:0]      pcount_r, pcount_nxt;
  logic [COUNTER_BITS-1:0] count_r, count_nxt;

  always_comb begin
    presc_nxt  = cfg_we ? cfg_wdata : presc_r;
    adv        = tick && (pcount_r >= presc_r);
    pcount_nxt = pcount_r;
    count_nxt  = count_r;
    if (tick) begin
      if (adv) begin
        pcount_nxt = '0;
        count_nxt  = count_r + COUNTER_BITS'(1);
      end else begin
        pcount_nxt = pcount_r + PRESC_W'(1);
      end
    end
  end

  // Count as it stands after this request.
  assign count = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r  <= PRESC_RESET;
      pcount_r <= '0;
      count_r  <= '0;
    end else begin
      presc_r  <= presc_nxt;
      pcount_r <= pcount_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mcat_channel.sv -----
// One compare channel: period, compare value, enable and one-shot flag.
`default_nettype none

module mcat_channel #(
  parameter int unsigned COUNTER_BITS = mcat_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mcat_pkg::mcat_chan_ctl_t ctl,
  input  wire logic [COUNTER_BITS-1:0] period,
  input  wire logic [COUNTER_BITS-1:0] count,
  output logic                         enabled,
  output logic                         fired
);
  import mcat_pkg::*;

  logic [COUNTER_BITS-1:0] cmp_r, cmp_nxt;
  logic [COUNTER_BITS-1:0] per_r, per_nxt;
  logic                    en_r, en_nxt;
  logic                    os_r, os_nxt;

  assign fired   = ctl.adv && en_r && (cmp_r == count);
  assign enabled = en_r;

  always_comb begin
    cmp_nxt = cmp_r;
    per_nxt = per_r;
    en_nxt  = en_r;
    os_nxt  = os_r;
    if (fired) begin
      cmp_nxt = cmp_r + per_r;
      if (os_r) begin
        en_nxt = 1'b0;
      end
    end
    if (ctl.arm) begin
      per_nxt = period;
      en_nxt  = ctl.en && (period != '0);
      if (ctl.en) begin
        cmp_nxt = count + period;
      end
    end
    if (ctl.set_one_shot) begin
      os_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
      os_r <= 1'b0;
    end else begin
      en_r <= en_nxt;
      os_r <= os_nxt;
    end
  end

  // Compare and period are only read once the channel has been armed.
  always_ff @(posedge clk) begin
    cmp_r <= cmp_nxt;
    per_r <= per_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/multi_channel_compare_alarm_timer.sv -----
// Top level of the multi-channel compare alarm timer.
`default_nettype none

// Multi-channel compare alarm timer. Each request is one of: a slow-clock
// tick, a channel configure, or a one-shot channel request. Ticks are divided
// by the prescaler register (advance once per cfg value + 1 ticks); on each
// divided tick the wrapping main counter steps and every enabled channel
// whose compare value equals the new count fires, reporting its bit in
// out_fired_mask and moving its compare value on by its period. A one-shot
// channel disables itself when it fires. Every request yields exactly one
// result carrying the counter value after that request. Throughput is one
// request per clock while no result is stalled: a request sits in the
// input register, the prescaler, the per-channel compares and the
// lowest-free-channel search resolve in one combinational pass, and the
// result lands in the output register, which drives out_valid. A stalled
// result holds in the output register while one more request is taken
// into the input register; only then does in_stall rise. Write cfg_wdata
// only while no request is in flight.
module multi_channel_compare_alarm_timer #(
  parameter int unsigned NUM_CHANNELS = mcat_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned COUNTER_BITS = mcat_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  // request channel
  input  wire logic                                        in_valid,
  output logic                                             in_stall,
  input  wire logic [mcat_pkg::OP_W-1:0]                   in_operation,
  input  wire logic [mcat_pkg::chan_w(NUM_CHANNELS)-1:0]   in_channel,
  input  wire logic [COUNTER_BITS-1:0]                     in_period_value,
  input  wire logic                                        in_enable,
  // result channel
  output logic                                             out_valid,
  input  wire logic                                        out_stall,
  output logic [NUM_CHANNELS-1:0]                          out_fired_mask,
  output logic                                             out_granted,
  output logic [mcat_pkg::chan_w(NUM_CHANNELS)-1:0]        out_granted_channel,
  output logic [COUNTER_BITS-1:0]                          out_counter_value,
  // prescaler register
  input  wire logic                                        cfg_we,
  input  wire logic [mcat_pkg::PRESC_W-1:0]                cfg_wdata
);
  import mcat_pkg::*;

  localparam int unsigned CW = chan_w(NUM_CHANNELS);

  // Input register
  logic                    s1_valid_r, s1_valid_nxt;
  logic [OP_W-1:0]         s1_op_r;
  logic [CW-1:0]           s1_ch_r;
  logic [COUNTER_BITS-1:0] s1_per_r;
  logic                    s1_en_r;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic [NUM_CHANNELS-1:0] fired_r;
  logic                    granted_r;
  logic [CW-1:0]           gch_r;
  logic [COUNTER_BITS-1:0] counter_r;

  logic in_acc;
  logic out_ready;
  logic s1_fire;

  // Decode
  logic is_tick, is_cfg, is_req;
  logic ch_in_range;

  // Datapath
  logic                    presc_adv;
  logic [COUNTER_BITS-1:0] count;
  logic [NUM_CHANNELS-1:0] chan_en;
  logic [NUM_CHANNELS-1:0] chan_fired;
  mcat_chan_ctl_t          chan_ctl [NUM_CHANNELS];

  logic                    free_found;
  logic [CW-1:0]           free_idx;
  logic                    grant;

  // Handshake: the output register frees when empty or taken this cycle.
  assign out_ready     = !out_valid_r || !out_stall;
  assign s1_fire       = s1_valid_r && out_ready;
  assign in_stall      = s1_valid_r && !out_ready;
  assign in_acc        = in_valid && !in_stall;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && out_stall);

  always_comb begin
    is_tick = 1'b0;
    is_cfg  = 1'b0;
    is_req  = 1'b0;
    case (s1_op_r)
      OP_TICK:    is_tick = 1'b1;
      OP_CONFIG:  is_cfg  = 1'b1;
      OP_ONESHOT: is_req  = 1'b1;
      default: begin
        // unassigned code: report zeros and the counter
      end
    endcase
  end

  assign ch_in_range = {1'b0, s1_ch_r} < (CW+1)'(NUM_CHANNELS);

  mcat_prescale #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_prescale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tick      (s1_fire && is_tick),
    .adv       (presc_adv),
    .count     (count)
  );

  // Lowest channel that is not enabled.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!free_found && !chan_en[i]) begin
        free_found = 1'b1;
        free_idx   = CW'(i);
      end
    end
  end

  assign grant = is_req && (s1_per_r != '0) && free_found;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
    logic cfg_hit, req_hit;

    assign cfg_hit = is_cfg && ch_in_range && (s1_ch_r == CW'(g));
    assign req_hit = grant && (free_idx == CW'(g));

    always_comb begin
      chan_ctl[g].adv          = presc_adv;
      chan_ctl[g].arm          = s1_fire && (cfg_hit || req_hit);
      chan_ctl[g].en           = is_cfg ? s1_en_r : 1'b1;
      chan_ctl[g].set_one_shot = s1_fire && req_hit;
    end

    mcat_channel #(
      .COUNTER_BITS (COUNTER_BITS)
    ) u_channel (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (chan_ctl[g]),
      .period  (s1_per_r),
      .count   (count),
      .enabled (chan_en[g]),
      .fired   (chan_fired[g])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request; hold while stalled.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_operation;
      s1_ch_r  <= in_channel;
      s1_per_r <= in_period_value;
      s1_en_r  <= in_enable;
    end
  end

  // Load the result as the request retires.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fired_r   <= chan_fired;
      granted_r <= grant;
      gch_r     <= grant ? free_idx : '0;
      counter_r <= count;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_fired_mask      = fired_r;
  assign out_granted         = granted_r;
  assign out_granted_channel = gch_r;
  assign out_counter_value   = counter_r;

endmodule

`default_nettype wire

// ----- rtl/mcat_checker.sv -----
// Port-level checker for the compare alarm timer, bound to the top level.
`default_nettype none

module mcat_checker #(
  parameter int unsigned NUM_CHANNELS = mcat_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned COUNTER_BITS = mcat_pkg::COUNTER_BITS_DEF
) (
  input wire logic                                      clk,
  input wire logic                                      rst_n,
  input wire logic                                      out_valid,
  input wire logic                                      out_stall,
  input wire logic [NUM_CHANNELS-1:0]                   out_fired_mask,
  input wire logic                                      out_granted,
  input wire logic [mcat_pkg::chan_w(NUM_CHANNELS)-1:0] out_granted_channel,
  input wire logic [COUNTER_BITS-1:0]                   out_counter_value
);
  import mcat_pkg::*;

  logic                    out_acc;
  logic [COUNTER_BITS-1:0] last_cnt_r, last_cnt_nxt;

  assign out_acc      = out_valid && !out_stall;
  assign last_cnt_nxt = out_acc ? out_counter_value : last_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= '0;
    end else begin
      last_cnt_r <= last_cnt_nxt;
    end
  end

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A grant and a fire never come from the same request.
  a_grant_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_granted && (out_fired_mask != '0)))
    else $error("grant and fire on one result");

  // The counter steps by at most one per result.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (out_counter_value == last_cnt_r) ||
                (out_counter_value == last_cnt_r + COUNTER_BITS'(1)))
    else $error("counter jumped");

  // Channels fire only on a counter step.
  a_fire_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (out_fired_mask != '0) |->
      (out_counter_value == last_cnt_r + COUNTER_BITS'(1)))
    else $error("fire without counter step");

  // No grant means a zero channel field.
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> (out_granted_channel == '0))
    else $error("channel reported without grant");

endmodule

bind multi_channel_compare_alarm_timer mcat_checker #(
  .NUM_CHANNELS (NUM_CHANNELS),
  .COUNTER_BITS (COUNTER_BITS)
) u_mcat_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_fired_mask      (out_fired_mask),
  .out_granted         (out_granted),
  .out_granted_channel (out_granted_channel),
  .out_counter_value   (out_counter_value)
);

`default_nettype wire

// ----- tb/tb_multi_channel_compare_alarm_timer.sv -----
// Self-checking testbench for the multi-channel compare alarm timer.
`default_nettype none

module tb_multi_channel_compare_alarm_timer;
  import mcat_pkg::*;

  localparam int unsigned NCH   = NUM_CHANNELS_DEF;
  localparam int unsigned CNT_W = COUNTER_BITS_DEF;
  localparam int unsigned CH_W  = 2;

  // Request code with no meaning; the block must leave all state alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [CNT_W-1:0]   PERIOD_MAX = '1;
  localparam logic [PRESC_W-1:0] PRESC_MAX  = '1;

  // Cycles with no request moving on either side before the run is aborted.
  localparam int unsigned WATCHDOG_CYCLES = 5000;
  // Length of the forced result hold-off in the backpressure test.
  localparam int unsigned HOLD_CYCLES     = 60;
  // Requests per prescaler setting in the random traffic.
  localparam int unsigned CHUNK_ITEMS     = 45;

  typedef struct packed {
    logic [NCH-1:0]   fired;
    logic             granted;
    logic [CH_W-1:0]  gch;
    logic [CNT_W-1:0] count;
  } alarm_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation;
  logic [CH_W-1:0]     in_channel;
  logic [CNT_W-1:0]    in_period_value;
  logic                in_enable;
  logic                out_valid;
  logic                out_stall;
  logic [NCH-1:0]      out_fired_mask;
  logic                out_granted;
  logic [CH_W-1:0]     out_granted_channel;
  logic [CNT_W-1:0]    out_counter_value;
  logic                cfg_we;
  logic [PRESC_W-1:0]  cfg_wdata;

  // Timer state as the block should hold it.
  logic [PRESC_W-1:0]  presc_limit;
  logic [PRESC_W-1:0]  presc_count;
  logic [CNT_W-1:0]    main_count;
  logic [CNT_W-1:0]    chan_cmp [NCH];
  logic [CNT_W-1:0]    chan_per [NCH];
  logic                chan_on [NCH];
  logic                chan_single [NCH];

  // Results owed by the block, oldest first.
  alarm_result_t       alarm_results_due[$];

  int                  error_count;
  int                  send_gap_pct;
  int                  out_stall_pct;
  int                  idle_cycles;
  int                  hold_left;
  // Hold-off requests raised by the tests and taken by the result side.
  int                  hold_req_cnt;
  int                  hold_ack_cnt;

  multi_channel_compare_alarm_timer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_channel          (in_channel),
    .in_period_value     (in_period_value),
    .in_enable           (in_enable),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_fired_mask      (out_fired_mask),
    .out_granted         (out_granted),
    .out_granted_channel (out_granted_channel),
    .out_counter_value   (out_counter_value),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Timer prediction
  // ------------------------------------------------------------------

  // Clear the predicted timer state to its power-on values.
  task automatic clear_timer_state();
    presc_count = '0;
    main_count  = '0;
    for (int i = 0; i < NCH; i++) begin
      chan_cmp[i]    = '0;
      chan_per[i]    = '0;
      chan_on[i]     = 1'b0;
      chan_single[i] = 1'b0;
    end
  endtask

  // Store the period; a zero period leaves the channel off. Arm the compare
  // only when enable is set, even for a zero period.
  task automatic arm_channel(input logic [CH_W-1:0] ch, input logic [CNT_W-1:0] period,
                             input logic en);
    chan_per[ch] = period;
    chan_on[ch]  = en && (period != '0);
    if (en)
      chan_cmp[ch] = main_count + period;
  endtask

  // Apply one request to the predicted state and return the result it owes.
  task automatic compute_alarm_result(input logic [OP_W-1:0] op,
                                      input logic [CH_W-1:0] ch,
                                      input logic [CNT_W-1:0] period,
                                      input logic en,
                                      output alarm_result_t r);
    bit found;
    r     = '0;
    found = 1'b0;
    case (op)
      OP_TICK: begin
        if (presc_count >= presc_limit) begin
          // Divided tick: step the counter, then compare every channel.
          presc_count = '0;
          main_count  = main_count + CNT_W'(1);
          for (int i = 0; i < NCH; i++) begin
            if (chan_on[i] && chan_cmp[i] == main_count) begin
              r.fired[i]  = 1'b1;
              chan_cmp[i] = chan_cmp[i] + chan_per[i];
              if (chan_single[i])
                chan_on[i] = 1'b0;
            end
          end
        end else begin
          presc_count = presc_count + PRESC_W'(1);
        end
      end
      OP_CONFIG: arm_channel(ch, period, en);
      OP_ONESHOT: begin
        // Grant the lowest channel that is off; refuse a zero period.
        if (period != '0) begin
          for (int i = 0; i < NCH; i++) begin
            if (!found && !chan_on[i]) begin
              found          = 1'b1;
              chan_single[i] = 1'b1;
              arm_channel(i[CH_W-1:0], period, 1'b1);
              r.granted      = 1'b1;
              r.gch          = i[CH_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    r.count = main_count;
  endtask

  // ------------------------------------------------------------------
  // Request monitor and result checker
  // ------------------------------------------------------------------

  // Check each accepted result against the oldest prediction, then predict
  // the request taken at this same edge. Values are sampled before any
  // nonblocking update of the edge lands, so ordering within the step does
  // not matter.
  always @(posedge clk) begin : monitor_blk
    alarm_result_t got;
    alarm_result_t want;
    if (!rst_n) begin
      clear_timer_state();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_fired_mask, out_granted, out_granted_channel,
                out_counter_value};
        if (alarm_results_due.size() == 0) begin
          error_count++;
          if (error_count < 50)
            $display("%0t: unexpected result: fired=%h granted=%b ch=%0d count=%h",
                     $time, got.fired, got.granted, got.gch, got.count);
        end else begin
          want = alarm_results_due.pop_front();
          if (got.fired !== want.fired || got.granted !== want.granted ||
              got.gch !== want.gch || got.count !== want.count) begin
            error_count++;
            if (error_count < 50)
              $display({"%0t: result mismatch: expected fired=%h granted=%b ch=%0d",
                        " count=%h, actual fired=%h granted=%b ch=%0d count=%h"},
                       $time, want.fired, want.granted, want.gch, want.count,
                       got.fired, got.granted, got.gch, got.count);
          end
        end
      end
      if (in_valid && !in_stall) begin
        compute_alarm_result(in_operation, in_channel, in_period_value,
                             in_enable, want);
        alarm_results_due.push_back(want);
      end
    end
  end

  // ------------------------------------------------------------------
  // Result side: random stall, or a forced hold-off on request
  // ------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_left    = HOLD_CYCLES;
      hold_ack_cnt = hold_req_cnt;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Abort when neither side has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $time, alarm_results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Request driving
  // ------------------------------------------------------------------

  // Offer one request, with random gaps ahead of it, and hold it until it is
  // taken. Return in the step of the accepting edge with valid still high.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                              input logic [CNT_W-1:0] period, input logic en);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_channel      <= ch;
    in_period_value <= period;
    in_enable       <= en;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // Send a tick with random contents in the fields a tick ignores.
  task automatic send_tick();
    send_request(OP_TICK, CH_W'($urandom_range(3)), CNT_W'($urandom),
                 1'($urandom_range(1)));
  endtask

  // Drop valid, let the last accepted request reach the queue, then wait
  // until every owed result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (alarm_results_due.size() != 0)
      @(posedge clk);
  endtask

  // Write the prescaler while nothing is in flight.
  task automatic set_prescaler(input logic [PRESC_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    presc_limit = value;
    cfg_we <= 1'b0;
  endtask

  // Mostly short periods so channels fire often; sometimes zero, the
  // largest value or a full random value.
  function automatic logic [CNT_W-1:0] pick_period();
    int k;
    k = $urandom_range(9);
    if (k == 0)
      return '0;
    else if (k == 1)
      return PERIOD_MAX;
    else if (k == 2)
      return CNT_W'($urandom);
    return CNT_W'($urandom_range(6, 1));
  endfunction

  function automatic logic [PRESC_W-1:0] pick_prescaler();
    int k;
    k = $urandom_range(19);
    if (k == 0)
      return PRESC_MAX;
    else if (k == 1)
      return PRESC_W'($urandom_range(4095));
    else if (k == 2)
      return PRESC_RESET;
    else if (k < 12)
      return '0;
    return PRESC_W'($urandom_range(3, 1));
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Tick through the first divided tick under the reset prescaler value.
  task automatic test_reset_prescaler();
    repeat (34) send_tick();
  endtask

  // Configure each channel: short period, zero period with enable (armed
  // but off), a period that wraps the compare, then disable one.
  task automatic test_channel_config();
    set_prescaler('0);
    send_request(OP_CONFIG, 2'd0, 24'd1, 1'b1);
    send_request(OP_CONFIG, 2'd1, 24'd3, 1'b1);
    send_request(OP_CONFIG, 2'd2, '0, 1'b1);
    send_request(OP_CONFIG, 2'd3, PERIOD_MAX, 1'b1);
    repeat (4) send_tick();
    send_request(OP_CONFIG, 2'd1, 24'd5, 1'b0);
    repeat (2) send_tick();
  endtask

  // Refuse a zero period, grant the lowest free channels, let the one-shots
  // fire and go off, then refuse a request when every channel is on.
  task automatic test_one_shot();
    send_request(OP_ONESHOT, 2'd3, '0, 1'b1);
    send_request(OP_ONESHOT, 2'd0, 24'd2, 1'b0);
    send_request(OP_ONESHOT, 2'd2, 24'd1, 1'b1);
    repeat (3) send_tick();
    send_request(OP_CONFIG, 2'd1, 24'd4, 1'b1);
    send_request(OP_CONFIG, 2'd2, 24'd2, 1'b1);
    send_request(OP_ONESHOT, 2'd1, 24'd7, 1'b1);
    repeat (5) send_tick();
    send_request(OP_ONESHOT, 2'd0, PERIOD_MAX, 1'b0);
  endtask

  // Unused code: nothing changes, result carries only the counter.
  task automatic test_unknown_op();
    send_request(OP_UNUSED, 2'd3, PERIOD_MAX, 1'b1);
    send_request(OP_UNUSED, 2'd0, '0, 1'b0);
  endtask

  // Run the count up under the largest prescaler, then lower the register
  // below the running count: the next tick must divide.
  task automatic test_prescaler_lowering();
    set_prescaler(PRESC_MAX);
    repeat (4) send_tick();
    set_prescaler(12'd2);
    repeat (3) send_tick();
  endtask

  // Hold the result side off for a long stretch while requests keep coming,
  // so the block fills and raises in_stall.
  task automatic test_output_backpressure();
    send_gap_pct  = 0;
    out_stall_pct = 0;
    set_prescaler('0);
    hold_req_cnt++;
    repeat (12) send_tick();
    send_request(OP_ONESHOT, 2'd0, 24'd3, 1'b1);
    repeat (4) send_tick();
  endtask

  // Random traffic, a fresh prescaler setting every chunk. Most requests are
  // ticks and configures that keep channels firing; the rest are one-shot
  // requests and unused codes.
  task automatic test_random_traffic(input int n_items, input int gap_pct,
                                     input int stall_pct);
    int k;
    send_gap_pct  = gap_pct;
    out_stall_pct = stall_pct;
    for (int n = 0; n < n_items; n++) begin
      if (n % CHUNK_ITEMS == 0)
        set_prescaler(pick_prescaler());
      k = $urandom_range(99);
      if (k < 50)
        send_tick();
      else if (k < 72)
        send_request(OP_CONFIG, CH_W'($urandom_range(3)), pick_period(),
                     $urandom_range(3) != 0);
      else if (k < 94)
        send_request(OP_ONESHOT, CH_W'($urandom_range(3)), pick_period(),
                     1'($urandom_range(1)));
      else
        send_request(OP_UNUSED, CH_W'($urandom_range(3)), CNT_W'($urandom),
                     1'($urandom_range(1)));
    end
  endtask

  // Wait out everything owed plus the pipeline depth, then report.
  task automatic finish_run();
    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  endtask

  initial begin
    send_gap_pct  = 13;
    out_stall_pct = 74;
    presc_limit   = PRESC_RESET;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operation    <= OP_TICK;
    in_channel      <= '0;
    in_period_value <= '0;
    in_enable       <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_prescaler();
    test_channel_config();
    test_one_shot();
    test_unknown_op();
    test_prescaler_lowering();
    test_random_traffic(270, 13, 74);
    test_random_traffic(270, 74, 13);
    test_output_backpressure();
    test_random_traffic(270, 0, 0);
    finish_run();
  end

endmodule

`default_nettype wire
